@@ rtl/pcs_pkg.sv @@
// Package for the pilot command shaper: payload structs, register indexes,
// fixed-point constants. Used by every module in rtl/.
package pcs_pkg;

  localparam int FracBits    = 14;
  localparam int LagW        = 24;
  localparam int DivW        = 48;
  localparam logic signed [15:0] OneQ = 16'sd16384;

  // rate*dt/1e6 rounded: add half of 1e6, drop 6 bits (1e6 = 64 * 15625),
  // then multiply by ceil(2^45/15625) and drop 45 bits. Exact for any
  // 20-bit rate and 16-bit dt.
  localparam logic [DivW-1:0] RateBias  = DivW'(500000);
  localparam logic [32:0]     RateRecip = 33'd2251799814;
  localparam int              RateShift = 45;

  localparam logic [1:0] RegExpo     = 2'd0;
  localparam logic [1:0] RegLag      = 2'd1;
  localparam logic [1:0] RegRate     = 2'd2;
  localparam logic [1:0] RegDeadband = 2'd3;

  typedef struct packed {
    logic signed [15:0] roll_stick;
    logic signed [15:0] pitch_stick;
    logic signed [15:0] yaw_stick;
    logic signed [15:0] roll_trim;
    logic signed [15:0] pitch_trim;
    logic signed [15:0] yaw_trim;
    logic        [15:0] time_step;
  } pcs_in_t;

  typedef struct packed {
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] roll_command;
    logic signed [15:0] pitch_command;
    logic signed [15:0] yaw_command;
    logic               roll_pitch_centered;
    logic               pitch_centered;
    logic               input_error;
  } pcs_out_t;

  // Request/response between sequencer and divider.
  typedef struct packed {
    logic            start;
    logic            neg;
    logic [DivW-1:0] mag;
    logic [DivW-1:0] den;
  } pcs_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
  } pcs_div_rsp_t;

endpackage

@@ rtl/pilot_command_shaper.sv @@
// Top level of the pilot command shaper: sequencer, shared multiplier and
// config registers. Depends on pcs_pkg and pcs_divider.
//
// One word in, one word out. For each of roll, pitch and yaw the block
// clamps stick plus trim to +/-1.0 (Q2.14), blends the value with its cube
// by the expo weight, moves the stored command toward that target through a
// first-order lag dt/(tau+dt), and limits the step to rate*dt. The lag
// division runs on a shared 48-bit bit-serial divider at one quotient bit
// per cycle. The divisions by ONE and ONE^2 are rounding shifts, and
// rate*dt/1e6 is a shift plus a reciprocal multiply; all multiplies share
// one 33x33 multiplier. With tau <= 1 the lag division is skipped. A zero
// time step goes straight to the output state and leaves the commands
// unchanged with input_error set. The input side is ready only while the
// sequencer is idle; the result sits in an output register until taken, so
// a new word may be accepted while it waits, and the sequencer holds in its
// output state only when a finished result would overwrite one not yet
// taken.
module pilot_command_shaper
  import pcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pcs_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pcs_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRate  = 4'd1;
  localparam logic [3:0] StSq    = 4'd2;
  localparam logic [3:0] StCube  = 4'd3;
  localparam logic [3:0] StBlnd1 = 4'd5;
  localparam logic [3:0] StBlnd2 = 4'd6;
  localparam logic [3:0] StLag1  = 4'd8;
  localparam logic [3:0] StLagW  = 4'd9;
  localparam logic [3:0] StLimit = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;
  localparam logic [3:0] StRateW = 4'd12;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;

  logic [14:0]     expo_q, db_q;
  logic [LagW-1:0] lag_q;
  logic [19:0]     rate_q;

  logic signed [15:0] cmd_q [3];
  logic signed [15:0] raw_q [3];
  logic        [15:0] dt_q;
  logic signed [DivW-1:0] acc_q, acc_d;     // product register
  logic signed [DivW-1:0] tmp_q, tmp_d;     // holds partial values
  logic signed [DivW-1:0] maxstep_q, maxstep_d;
  logic signed [DivW-1:0] target_q, target_d;
  logic signed [15:0] newcmd;
  logic out_valid_q;
  logic out_load;
  pcs_out_t out_q;

  pcs_div_req_t div_req;
  pcs_div_rsp_t div_rsp;

  pcs_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Shared multiplier operands.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [16:0] sum [3];
  logic signed [15:0] rawc [3];
  logic [15:0] expo_sat;
  logic signed [15:0] x, c;
  logic signed [DivW-1:0] lo, hi, lagged;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = (i == 0) ? in_data_i.roll_stick + in_data_i.roll_trim
             : (i == 1) ? in_data_i.pitch_stick + in_data_i.pitch_trim
             : in_data_i.yaw_stick + in_data_i.yaw_trim;
      if (sum[i] > 17'sd16384) rawc[i] = OneQ;
      else if (sum[i] < -17'sd16384) rawc[i] = -OneQ;
      else rawc[i] = sum[i][15:0];
    end
  end

  assign expo_sat = ({1'b0, expo_q} > 16'd16384) ? 16'd16384 : {1'b0, expo_q};
  assign x = raw_q[axis_q];
  assign c = cmd_q[axis_q];
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  // Load the result register once it is empty or being emptied.
  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);

  // Division request helper.
  function automatic pcs_div_req_t mk_req(logic signed [DivW-1:0] num,
                                         logic [DivW-1:0] den);
    pcs_div_req_t r;
    r.start = 1'b1;
    r.neg   = num[DivW-1];
    r.mag   = num[DivW-1] ? -num : num;
    r.den   = den;
    return r;
  endfunction

  // Divide by 2^sh, round to nearest with ties away from zero.
  function automatic logic signed [DivW-1:0] round_shift(logic signed [DivW-1:0] num,
                                                         int sh);
    logic signed [DivW-1:0] bias;
    bias = (DivW'(1) <<< (sh - 1)) - DivW'(num[DivW-1]);
    return (num + bias) >>> sh;
  endfunction

  always_comb begin
    state_d = state_q; axis_d = axis_q;
    acc_d = acc_q; tmp_d = tmp_q; maxstep_d = maxstep_q; target_d = target_q;
    div_req = '0;
    mul_a = '0; mul_b = '0;
    lo = '0; hi = '0; lagged = '0; newcmd = c;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          axis_d = '0;
          state_d = (in_data_i.time_step == '0) ? StOut : StRate;
        end
      end
      StRate: begin
        mul_a = 33'(signed'({1'b0, rate_q}));
        mul_b = 33'(signed'({1'b0, dt_q}));
        acc_d = mul_p[DivW-1:0] + RateBias;
        state_d = StRateW;
      end
      StRateW: begin
        // Drop 6 bits, then divide by 15625 through the reciprocal.
        mul_a = signed'({1'b0, acc_q[37:6]});
        mul_b = signed'(RateRecip);
        maxstep_d = DivW'(mul_p[65:RateShift]);
        state_d = StSq;
      end
      StSq: begin
        mul_a = 33'(x); mul_b = 33'(x);
        tmp_d = mul_p[DivW-1:0];
        state_d = StCube;
      end
      StCube: begin
        mul_a = tmp_q[32:0]; mul_b = 33'(x);
        tmp_d = round_shift(mul_p[DivW-1:0], 2 * FracBits);
        state_d = StBlnd1;
      end
      StBlnd1: begin
        mul_a = 33'(signed'({1'b0, expo_sat})); mul_b = tmp_q[32:0];
        acc_d = mul_p[DivW-1:0];
        state_d = StBlnd2;
      end
      StBlnd2: begin
        mul_a = 33'(signed'({1'b0, 16'(OneQ) - expo_sat})); mul_b = 33'(x);
        target_d = round_shift(acc_q + mul_p[DivW-1:0], FracBits);
        state_d = (lag_q <= LagW'(1)) ? StLimit : StLag1;
      end
      StLag1: begin
        mul_a = target_q[32:0] - 33'(c); mul_b = 33'(signed'({1'b0, dt_q}));
        div_req = mk_req(mul_p[DivW-1:0], DivW'(lag_q) + DivW'(dt_q));
        state_d = StLagW;
      end
      StLagW: begin
        if (div_rsp.done) begin
          target_d = DivW'(c) + div_rsp.quo;
          state_d = StLimit;
        end
      end
      StLimit: begin
        // Clamp lagged value to the rate window around the stored command.
        lagged = target_q;
        lo = DivW'(c) - maxstep_q;
        hi = DivW'(c) + maxstep_q;
        if (lagged < lo) lagged = lo;
        else if (lagged > hi) lagged = hi;
        newcmd = lagged[15:0];
        if (axis_q == 2'd2) state_d = StOut;
        else begin
          axis_d = axis_q + 1'b1;
          state_d = StSq;
        end
      end
      StOut: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  logic [16:0] ab0, ab1;
  assign ab0 = raw_q[0][15] ? 17'(-raw_q[0]) : 17'(raw_q[0]);
  assign ab1 = raw_q[1][15] ? 17'(-raw_q[1]) : 17'(raw_q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; axis_q <= '0; out_valid_q <= 1'b0;
      expo_q <= '0; lag_q <= '0; rate_q <= 20'hFFFFF; db_q <= '0;
      for (int i = 0; i < 3; i++) cmd_q[i] <= '0;
    end else begin
      state_q <= state_d; axis_q <= axis_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegExpo:     expo_q <= cfg_data_i[14:0];
          RegLag:      lag_q  <= cfg_data_i[LagW-1:0];
          RegRate:     rate_q <= cfg_data_i[19:0];
          RegDeadband: db_q   <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (state_q == StLimit) cmd_q[axis_q] <= newcmd;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; tmp_q <= tmp_d; maxstep_q <= maxstep_d; target_q <= target_d;
    if (in_valid_i && in_ready_o) begin
      for (int i = 0; i < 3; i++) raw_q[i] <= rawc[i];
      dt_q <= in_data_i.time_step;
    end
    if (out_load) begin
      out_q.roll_raw  <= raw_q[0];
      out_q.pitch_raw <= raw_q[1];
      out_q.yaw_raw   <= raw_q[2];
      out_q.roll_command  <= cmd_q[0];
      out_q.pitch_command <= cmd_q[1];
      out_q.yaw_command   <= cmd_q[2];
      out_q.roll_pitch_centered <= (ab0 <= {2'b0, db_q}) && (ab1 <= {2'b0, db_q});
      out_q.pitch_centered      <= (ab1 <= {2'b0, db_q});
      out_q.input_error         <= (dt_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/pcs_divider.sv @@
// Radix-2 restoring divider, round to nearest with ties away from zero.
// Depends on pcs_pkg. One quotient bit per cycle.
module pcs_divider
  import pcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pcs_div_req_t req_i,
  output pcs_div_rsp_t rsp_o
);

  logic [DivW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [$clog2(DivW+1)-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [DivW:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      // Bias by den/2 so truncation rounds half away from zero.
      quo_d  = req_i.mag + (req_i.den >> 1);
      rem_d  = '0;
      den_d  = req_i.den;
      neg_d  = req_i.neg;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(DivW+1))'(DivW-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) quo_d = -quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ tb/tb_top.sv @@
// Testbench for pilot_command_shaper: directed and random stick/trim words,
// a class-based predictor and scoreboard, random idling on both channels.
// Depends on pcs_pkg and the RTL under rtl/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  // Predicts shaped commands from the register copy and stored commands,
  // and holds the expected output words in arrival order.
  class shaper_scoreboard;
    longint expo_w, lag_us, rate_q, db_q;
    longint cmd[3];
    pcs_out_t pending[$];
    int errors;

    function new();
      expo_w = 0; lag_us = 0; rate_q = 1048575; db_q = 0;
      cmd[0] = 0; cmd[1] = 0; cmd[2] = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegExpo:     expo_w = val[14:0];
        RegLag:      lag_us = val[LagW-1:0];
        RegRate:     rate_q = val[19:0];
        RegDeadband: db_q   = val[14:0];
        default: ;
      endcase
    endfunction

    // Round to nearest, ties away from zero; den is positive.
    function longint rdiv(longint num, longint den);
      longint q;
      if (num < 0) begin
        q = (-num + den / 2) / den;
        return -q;
      end
      return (num + den / 2) / den;
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void note_input(pcs_in_t w);
      longint raw[3], e, dt, stepmax, cube, tgt, lagged;
      pcs_out_t r;
      raw[0] = lim(longint'(w.roll_stick) + w.roll_trim, -16384, 16384);
      raw[1] = lim(longint'(w.pitch_stick) + w.pitch_trim, -16384, 16384);
      raw[2] = lim(longint'(w.yaw_stick) + w.yaw_trim, -16384, 16384);
      dt = w.time_step;
      e = expo_w > 16384 ? 16384 : expo_w;
      if (dt != 0) begin
        stepmax = rdiv(rate_q * dt, 1000000);
        for (int i = 0; i < 3; i++) begin
          cube = rdiv(raw[i] * raw[i] * raw[i], 64'd268435456);
          tgt = rdiv((16384 - e) * raw[i] + e * cube, 16384);
          if (lag_us <= 1) lagged = tgt;
          else lagged = cmd[i] + rdiv((tgt - cmd[i]) * dt, lag_us + dt);
          cmd[i] = lim(lagged, cmd[i] - stepmax, cmd[i] + stepmax);
        end
      end
      r.roll_raw = 16'(raw[0]); r.pitch_raw = 16'(raw[1]); r.yaw_raw = 16'(raw[2]);
      r.roll_command = 16'(cmd[0]); r.pitch_command = 16'(cmd[1]);
      r.yaw_command = 16'(cmd[2]);
      r.roll_pitch_centered = mag(raw[0]) <= db_q && mag(raw[1]) <= db_q;
      r.pitch_centered = mag(raw[1]) <= db_q;
      r.input_error = dt == 0;
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(pcs_out_t g);
      pcs_out_t x;
      if (pending.size() == 0) begin
        report("unexpected word", 1, 0);
        return;
      end
      x = pending.pop_front();
      if (g.roll_raw != x.roll_raw) report("roll_raw", g.roll_raw, x.roll_raw);
      if (g.pitch_raw != x.pitch_raw) report("pitch_raw", g.pitch_raw, x.pitch_raw);
      if (g.yaw_raw != x.yaw_raw) report("yaw_raw", g.yaw_raw, x.yaw_raw);
      if (g.roll_command != x.roll_command)
        report("roll_command", g.roll_command, x.roll_command);
      if (g.pitch_command != x.pitch_command)
        report("pitch_command", g.pitch_command, x.pitch_command);
      if (g.yaw_command != x.yaw_command)
        report("yaw_command", g.yaw_command, x.yaw_command);
      if (g.roll_pitch_centered !== x.roll_pitch_centered)
        report("roll_pitch_centered", g.roll_pitch_centered, x.roll_pitch_centered);
      if (g.pitch_centered !== x.pitch_centered)
        report("pitch_centered", g.pitch_centered, x.pitch_centered);
      if (g.input_error !== x.input_error)
        report("input_error", g.input_error, x.input_error);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  pcs_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  pcs_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  shaper_scoreboard sb = new();
  int words_sent = 0, words_seen = 0, zero_steps = 0;
  bit stall_free = 0;  // hold both sides busy-free for a stretch
  bit sending_done = 0;

  pilot_command_shaper dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function int gap_len();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 600);
    return $urandom_range(0, 3);
  endfunction

  task idle(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Present one word and hold it until the block takes it. Always idle
  // before presenting; the block is never ready right after an accept anyway.
  task send_word(pcs_in_t w);
    idle(gap_len() + 1);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
    words_sent++;
    if (w.time_step == 0) zero_steps++;
    in_valid_i <= 1'b0;
  endtask

  // Leave valid up so writes can follow back to back; set_all drops it.
  task write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  // Drain outstanding words before touching the registers.
  task wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    idle(20);
  endtask

  task set_all(int e, int l, int r, int d);
    wait_idle();
    write_reg(RegExpo, e);
    write_reg(RegLag, l);
    write_reg(RegRate, r);
    write_reg(RegDeadband, d);
    cfg_valid_i <= 1'b0;
  endtask

  function pcs_in_t mk(int rs, int ps, int ys, int rt, int pt, int yt, int dt);
    pcs_in_t w;
    w.roll_stick = 16'(rs); w.pitch_stick = 16'(ps); w.yaw_stick = 16'(ys);
    w.roll_trim = 16'(rt); w.pitch_trim = 16'(pt); w.yaw_trim = 16'(yt);
    w.time_step = 16'(dt);
    return w;
  endfunction

  // Stick values: mostly in range, some any bit pattern.
  function logic [15:0] rnd_axis();
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function pcs_in_t rnd_word();
    pcs_in_t w;
    int k;
    w.roll_stick = rnd_axis(); w.pitch_stick = rnd_axis(); w.yaw_stick = rnd_axis();
    w.roll_trim = rnd_axis(); w.pitch_trim = rnd_axis(); w.yaw_trim = rnd_axis();
    k = $urandom_range(0, 19);
    if (k == 0) w.time_step = '0;
    else if (k < 4) w.time_step = 16'($urandom());
    else w.time_step = 16'($urandom_range(1, 20000));
    return w;
  endfunction

  // Output side: take words with random stalls and check each one.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(out_data_o);
      words_seen++;
    end
    out_ready_i <= (gap_len() == 0);
  end

  initial begin
    idle(12);
    rst_ni <= 1'b1;
    idle(4);

    // Directed: reset registers first, then extremes.
    send_word(mk(16384, -16384, 0, 0, 0, 0, 1000));
    send_word(mk(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 65535));
    send_word(mk(100, 200, 300, 0, 0, 0, 0));
    set_all(16384, 0, 1048575, 16384);
    send_word(mk(16384, 16384, -16384, 0, 0, 0, 20000));
    send_word(mk(5000, 0, -8000, 3000, 0, -9000, 1));
    set_all(32767, 1, 0, 32767);
    send_word(mk(-16384, 8000, 16384, 0, 0, 0, 65535));
    send_word(mk(0, 0, 0, 0, 0, 0, 0));
    set_all(8192, 2, 50000, 500);
    send_word(mk(400, -400, 16384, 100, 0, 0, 1000));
    send_word(mk(600, 500, -16384, 0, 0, 0, 1000));
    send_word(mk(-16384, 16384, 16384, 0, 0, 0, 0));
    set_all(4000, 24'hffffff, 1048575, 0);
    send_word(mk(16384, -16384, 16384, 0, 0, 0, 65535));
    send_word(mk(0, 0, 0, 0, 0, 0, 3));

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 10; ph++) begin
      set_all($urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 16384),
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) :
              ($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(2, 50000)),
              $urandom_range(0, 3) == 0 ? 1048575 : $urandom_range(0, 1048575),
              $urandom_range(0, 4) == 0 ? $urandom_range(0, 32767)
                                        : $urandom_range(0, 2000));
      stall_free = (ph % 3 == 2);
      repeat (64) send_word(rnd_word());
    end
    stall_free = 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    idle(600);
    $display("covered %0d words (%0d zero time steps), %0d results checked",
             words_sent, zero_steps, words_seen);
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // Generous bound: about 650 words plus long stalls on both sides.
  initial begin
    #(12ns * 3000000);
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
